// File: rtl/core/phlb_pkg.sv
package phlb_pkg;

	localparam int TABLE_DEPTH = 128;
	localparam int GATE_W      = 7;
	localparam int COUNT_W     = 8;
	localparam int POS_W       = 16;
	localparam int HASH_W      = 32;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;

	// fixed-point shift of the reciprocal used to fold the gate sum into range
	localparam int SEL_SHIFT = 18;

	localparam logic MODE_BYTE  = 1'b0;
	localparam logic MODE_TABLE = 1'b1;

	localparam logic METHOD_OAT = 1'b0;
	localparam logic METHOD_SUM = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_OFFSET = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HASH_METHOD   = 2'd2;

	localparam logic [POS_W-1:0] WINDOW_OFFSET_RST = 16'd26;
	localparam logic [POS_W-1:0] WINDOW_SIZE_RST   = 16'd8;
	localparam logic [POS_W-1:0] POS_MAX           = 16'hFFFF;

	typedef struct packed {
		logic [GATE_W-1:0]  start;
		logic [COUNT_W-1:0] count;
	} split_entry_t;

	typedef struct packed {
		logic [HASH_W-1:0] hash;
		logic              short_pkt;
		logic              method;
	} hash_job_t;

endpackage

// File: rtl/core/phlb_if.sv
interface phlb_in_if;
	import phlb_pkg::*;
	logic               valid;
	logic               ready;
	logic               mode;
	logic [7:0]         data_byte;
	logic               last_byte;
	logic [GATE_W-1:0]  in_gate;
	logic [GATE_W-1:0]  entry_start;
	logic [COUNT_W-1:0] entry_count;

	modport source (output valid, mode, data_byte, last_byte, in_gate, entry_start,
		entry_count, input ready);
	modport sink (input valid, mode, data_byte, last_byte, in_gate, entry_start,
		entry_count, output ready);
endinterface

interface phlb_out_if;
	import phlb_pkg::*;
	logic              valid;
	logic              ready;
	logic [GATE_W-1:0] out_gate;
	logic              dropped;
	logic              short_packet;

	modport source (output valid, out_gate, dropped, short_packet, input ready);
	modport sink (input valid, out_gate, dropped, short_packet, output ready);
endinterface

interface phlb_cfg_if;
	import phlb_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  reg_index;
	logic [CFG_DATA_W-1:0] wdata;

	modport source (output valid, reg_index, wdata, input ready);
	modport sink (input valid, reg_index, wdata, output ready);
endinterface

// File: rtl/core/packet_hash_load_balancer.sv
// Packet hash load balancer. Packet bytes and split-table writes are taken one per cycle.
// A last byte is answered by one result. The split-table read and the hash job are registered
// together; the selector loads them, runs the finishing mix (one-at-a-time hash only, the
// byte sum skips it), the bit-serial hash-modulo-count loop and the wrap and fold steps that
// bring the gate into range, then loads the output register. The selector sets the pace
// between packets: a further last byte waits until the selector has handed its result to the
// output register, while the bytes before it keep flowing.
// The split table is a 128-entry synchronous memory that reads as zero after reset, so an
// unwritten gate drops its packets; configuration writes are always taken.
module packet_hash_load_balancer import phlb_pkg::*; #(
	parameter int NUM_GATES = 128
) (
	input logic        clk,
	input logic        arst_n,
	phlb_in_if.sink    pkt,
	phlb_out_if.source res,
	phlb_cfg_if.sink   cfg
);

	logic [POS_W-1:0] window_offset_q;
	logic [POS_W-1:0] window_size_q;
	logic             hash_method_q;
	logic             pkt_acc;
	logic             byte_en;
	logic             unit_busy;
	logic             job_valid_s1;
	hash_job_t        job_s1;
	split_entry_t     tbl_wr;
	split_entry_t     tbl_rd;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_offset_q <= WINDOW_OFFSET_RST;
			window_size_q   <= WINDOW_SIZE_RST;
			hash_method_q   <= METHOD_OAT;
		end else if (cfg.valid) begin
			case (cfg.reg_index)
				CFG_WINDOW_OFFSET: window_offset_q <= cfg.wdata;
				CFG_WINDOW_SIZE:   window_size_q   <= cfg.wdata;
				CFG_HASH_METHOD:   hash_method_q   <= cfg.wdata[0];
				default: ;
			endcase
		end
	end

	// hold a last byte while the previous packet still occupies the selector
	assign pkt.ready = !(pkt.mode == MODE_BYTE && pkt.last_byte) ||
		(!job_valid_s1 && !unit_busy);
	assign pkt_acc   = pkt.valid && pkt.ready;
	assign byte_en   = pkt_acc && (pkt.mode == MODE_BYTE);

	assign tbl_wr.start = pkt.entry_start;
	assign tbl_wr.count = pkt.entry_count;

	phlb_split_tbl u_tbl (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (pkt_acc && (pkt.mode == MODE_TABLE)),
		.wr_addr (pkt.in_gate),
		.wr_data (tbl_wr),
		.rd_addr (pkt.in_gate),
		.rd_data (tbl_rd)
	);

	phlb_hash_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.byte_en       (byte_en),
		.data_byte     (pkt.data_byte),
		.last_byte     (pkt.last_byte),
		.window_offset (window_offset_q),
		.window_size   (window_size_q),
		.hash_method   (hash_method_q),
		.job_valid_s1  (job_valid_s1),
		.job_s1        (job_s1)
	);

	phlb_sel_unit #(
		.NUM_GATES (NUM_GATES)
	) u_sel (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid_s1),
		.job       (job_s1),
		.entry     (tbl_rd),
		.busy      (unit_busy),
		.res       (res)
	);

endmodule

// File: rtl/core/phlb_split_tbl.sv
module phlb_split_tbl import phlb_pkg::*; (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [$clog2(TABLE_DEPTH)-1:0] wr_addr,
	input  split_entry_t                   wr_data,
	input  logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
	output split_entry_t                   rd_data
);

	split_entry_t           mem [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] valid_q;
	split_entry_t           rd_data_q;
	logic                   rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	// an entry never written since reset reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			rd_valid_q <= valid_q[rd_addr];
		end
	end

	assign rd_data = rd_valid_q ? rd_data_q : '0;

endmodule

// File: rtl/core/phlb_hash_front.sv
module phlb_hash_front import phlb_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             byte_en,
	input  logic [7:0]       data_byte,
	input  logic             last_byte,
	input  logic [POS_W-1:0] window_offset,
	input  logic [POS_W-1:0] window_size,
	input  logic             hash_method,
	output logic             job_valid_s1,
	output hash_job_t        job_s1
);

	logic [POS_W-1:0]  pos_q;
	logic [HASH_W-1:0] hash_q;
	logic [POS_W:0]    win_end;
	logic              pos_sat;
	logic              in_win;
	logic [HASH_W-1:0] byte_ext;
	logic [HASH_W-1:0] oat_sum;
	logic [HASH_W-1:0] mixed;
	logic [HASH_W-1:0] hash_next;
	logic [POS_W-1:0]  count_after;
	logic              short_pkt;

	assign win_end  = {1'b0, window_offset} + {1'b0, window_size};
	assign pos_sat  = (pos_q == POS_MAX);
	assign in_win   = !pos_sat && (pos_q >= window_offset) && ({1'b0, pos_q} < win_end);
	assign byte_ext = {{(HASH_W-8){1'b0}}, data_byte};

	// (h + b) * 1025 as one multi-operand add, then the xor-shift
	assign oat_sum = hash_q + byte_ext + (hash_q << 10) + (byte_ext << 10);

	always_comb begin
		if (hash_method == METHOD_OAT) begin
			mixed = oat_sum ^ (oat_sum >> 6);
		end else begin
			mixed = hash_q + byte_ext;
		end
	end

	assign hash_next   = in_win ? mixed : hash_q;
	assign count_after = pos_sat ? pos_q : pos_q + 1'b1;
	assign short_pkt   = (win_end > {1'b0, count_after});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			hash_q       <= '0;
			job_valid_s1 <= 1'b0;
		end else begin
			job_valid_s1 <= byte_en && last_byte;
			if (byte_en) begin
				if (last_byte) begin
					pos_q  <= '0;
					hash_q <= '0;
				end else begin
					pos_q  <= count_after;
					hash_q <= hash_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (byte_en && last_byte) begin
			job_s1.hash      <= hash_next;
			job_s1.short_pkt <= short_pkt;
			job_s1.method    <= hash_method;
		end
	end

endmodule

// File: rtl/core/phlb_sel_unit.sv
module phlb_sel_unit import phlb_pkg::*; #(
	parameter int NUM_GATES = 128
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       job_valid,
	input  hash_job_t  job,
	input  split_entry_t entry,
	output logic       busy,
	phlb_out_if.source res
);

	localparam int HASH_CNT_W = $clog2(HASH_W);
	localparam int SUM_W      = GATE_W + 2;
	localparam int RECIP_W    = SEL_SHIFT;
	localparam int FOLD_W     = SUM_W + 1;
	localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'((1 << SEL_SHIFT) / NUM_GATES);
	localparam logic [FOLD_W-1:0]  GATES_C = FOLD_W'(NUM_GATES);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MIX_A,
		S_MIX_B,
		S_DIV,
		S_WRAP,
		S_FOLD,
		S_DONE
	} sel_state_t;

	sel_state_t            state_q;
	logic [HASH_CNT_W-1:0] bit_cnt_q;
	logic [HASH_W-1:0]     hash_q;
	logic [COUNT_W-1:0]    rem_q;
	logic [GATE_W-1:0]     start_q;
	logic [COUNT_W-1:0]    count_q;
	logic                  short_q;
	logic [SUM_W-1:0]      sum_q;
	logic [SUM_W-1:0]      quot_q;
	logic [GATE_W-1:0]     gate_q;

	logic [HASH_W-1:0]         mix_a;
	logic [COUNT_W:0]          rem_shift;
	logic [COUNT_W:0]          rem_sub;
	logic [SUM_W-1:0]          sum;
	logic [SUM_W+RECIP_W-1:0]  recip_prod;
	logic [2*FOLD_W-1:0]       fold_prod;
	logic [FOLD_W-1:0]         fold_r;
	logic [FOLD_W-1:0]         fold_fix;
	logic                      load_out;

	assign busy = (state_q != S_IDLE);

	assign mix_a     = hash_q + (hash_q << 3);
	assign rem_shift = {rem_q, hash_q[HASH_W-1]};
	assign rem_sub   = rem_shift - {1'b0, count_q};
	assign sum       = {2'b00, start_q} + {1'b0, rem_q};
	assign recip_prod = sum * RECIP_C;
	assign fold_prod = {1'b0, quot_q} * GATES_C;
	assign fold_r    = {1'b0, sum_q} - fold_prod[FOLD_W-1:0];
	assign fold_fix  = (fold_r >= GATES_C) ? fold_r - GATES_C : fold_r;
	assign load_out  = (state_q == S_DONE) && (!res.valid || res.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			bit_cnt_q <= '0;
			res.valid <= 1'b0;
		end else begin
			if (res.valid && res.ready && !load_out) begin
				res.valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (job_valid) begin
						bit_cnt_q <= HASH_CNT_W'(HASH_W - 1);
						state_q   <= (job.method == METHOD_OAT) ? S_MIX_A : S_DIV;
					end
				end
				S_MIX_A: state_q <= S_MIX_B;
				S_MIX_B: state_q <= S_DIV;
				S_DIV: begin
					bit_cnt_q <= bit_cnt_q - 1'b1;
					if (bit_cnt_q == '0) begin
						state_q <= S_WRAP;
					end
				end
				S_WRAP: state_q <= S_FOLD;
				S_FOLD: state_q <= S_DONE;
				S_DONE: begin
					if (load_out) begin
						res.valid <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				hash_q  <= job.hash;
				short_q <= job.short_pkt;
				start_q <= entry.start;
				count_q <= entry.count;
				rem_q   <= '0;
			end
			S_MIX_A: hash_q <= mix_a ^ (mix_a >> 11);
			S_MIX_B: hash_q <= hash_q + (hash_q << 15);
			S_DIV: begin
				// restoring remainder step, one hash bit per cycle
				hash_q <= hash_q << 1;
				rem_q  <= (rem_shift >= {1'b0, count_q}) ? rem_sub[COUNT_W-1:0]
					: rem_shift[COUNT_W-1:0];
			end
			S_WRAP: begin
				sum_q  <= sum;
				quot_q <= recip_prod[SEL_SHIFT +: SUM_W];
			end
			S_FOLD: gate_q <= (count_q == '0) ? '0 : fold_fix[GATE_W-1:0];
			S_DONE: begin
				if (load_out) begin
					res.out_gate     <= gate_q;
					res.dropped      <= (count_q == '0);
					res.short_packet <= short_q;
				end
			end
			default: ;
		endcase
	end

endmodule

// File: rtl/core/phlb_checker.sv
module phlb_checker import phlb_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              pkt_valid,
	input logic              pkt_ready,
	input logic              pkt_mode,
	input logic              pkt_last_byte,
	input logic              res_valid,
	input logic              res_ready,
	input logic [GATE_W-1:0] res_out_gate,
	input logic              res_dropped,
	input logic              res_short_packet
);

	logic last_acc;

	assign last_acc = pkt_valid && pkt_ready && (pkt_mode == MODE_BYTE) && pkt_last_byte;

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result request withdrawn while stalled");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res_out_gate) && $stable(res_dropped) &&
			$stable(res_short_packet))
		else $error("stalled result changed");

	a_drop_gate: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_dropped |-> res_out_gate == '0)
		else $error("dropped packet carries a nonzero gate");

	a_last_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		last_acc |=> !last_acc)
		else $error("two packet ends accepted back to back");

endmodule

bind packet_hash_load_balancer phlb_checker u_phlb_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.pkt_valid        (pkt.valid),
	.pkt_ready        (pkt.ready),
	.pkt_mode         (pkt.mode),
	.pkt_last_byte    (pkt.last_byte),
	.res_valid        (res.valid),
	.res_ready        (res.ready),
	.res_out_gate     (res.out_gate),
	.res_dropped      (res.dropped),
	.res_short_packet (res.short_packet)
);
